FILE: src/deq_pkg.sv
// ---------------------------------------------------------------------------
// deq_pkg
// Types and codes shared by the deque block.
// ---------------------------------------------------------------------------
package deq_pkg;

    localparam int MODE_W  = 4;
    localparam int POS_W   = 4;
    localparam int CNT_W   = 5;
    localparam int STAT_W  = 2;
    localparam int WORD_W  = 32;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 4'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ERASE      = 4'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd5;
    localparam logic [MODE_W-1:0] MODE_REVERSE    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SORT       = 4'd7;
    localparam logic [MODE_W-1:0] MODE_RESIZE     = 4'd8;
    localparam logic [MODE_W-1:0] MODE_ASSIGN     = 4'd9;
    localparam logic [MODE_W-1:0] MODE_QUERY      = 4'd10;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDER  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVER   = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  count;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
        logic [CNT_W-1:0]  occupancy;
        logic              is_empty;
        logic [STAT_W-1:0] status;
    } rsp_t;

endpackage

FILE: src/deq_if.sv
// ---------------------------------------------------------------------------
// deq_cmd_if / deq_rsp_if
// Valid/ready channels for command and result items.
// ---------------------------------------------------------------------------
interface deq_cmd_if;
    import deq_pkg::*;
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface deq_rsp_if;
    import deq_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/double_ended_queue_top.sv
// ---------------------------------------------------------------------------
// double_ended_queue_top
// Bounded deque of signed words in a ring store, one result per command.
// ---------------------------------------------------------------------------
//  channel | dir | payload
//  cmd     | in  | mode, value, position, count
//  rsp     | out | front_value, back_value, occupancy, is_empty, status
//
//  One store write and one registered read a cycle, driven by a small
//  sequencer. Push/pop/clear/query: EXEC, FRNT, BACK, BCAP, then result in
//  OUT. Erase adds ER_RD/ER_WR per entry shifted; resize/assign add S_WR per
//  entry written; reverse adds RV_RD/RV_FAR/RV_WN/RV_WF per pair; sort
//  (insertion) adds SKEY/SLOAD/SCMP steps. rst_n clears head and count;
//  no command is taken until the result item has been taken.
// ---------------------------------------------------------------------------
module double_ended_queue_top #(
    parameter int DEPTH = 16
) (
    input logic clk,
    input logic rst_n,
    deq_cmd_if.sink   cmd,
    deq_rsp_if.source rsp
);
    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam int XW = (NW > CNT_W) ? NW + 1 : CNT_W + 1;
    localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);
    localparam logic [NW-1:0] ONE_N   = NW'(1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_WR     = 4'd2;
    localparam logic [3:0] S_ER_RD  = 4'd3;
    localparam logic [3:0] S_ER_WR  = 4'd4;
    localparam logic [3:0] S_RV_RD  = 4'd5;
    localparam logic [3:0] S_RV_FAR = 4'd6;
    localparam logic [3:0] S_RV_WN  = 4'd7;
    localparam logic [3:0] S_RV_WF  = 4'd8;
    localparam logic [3:0] S_SKEY   = 4'd9;
    localparam logic [3:0] S_SLOAD  = 4'd10;
    localparam logic [3:0] S_SCMP   = 4'd11;
    localparam logic [3:0] S_FRNT   = 4'd12;
    localparam logic [3:0] S_BACK   = 4'd13;
    localparam logic [3:0] S_BCAP   = 4'd14;
    localparam logic [3:0] S_OUT    = 4'd15;

    logic [WORD_W-1:0] mem [DEPTH];

    logic [3:0]        state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    cmd_t              cmd_reg, cmd_next;
    logic [NW-1:0]     i_reg, i_next;
    logic [NW-1:0]     j_reg, j_next;
    logic [NW-1:0]     lim_reg, lim_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] key_reg, key_next;
    logic [WORD_W-1:0] rd_reg;
    rsp_t              rsp_reg, rsp_next;
    logic [STAT_W-1:0] st_reg, st_next;

    logic              we;
    logic [NW-1:0]     widx, ridx;
    logic [WORD_W-1:0] wdata;
    logic [AW-1:0]     wslot, rslot;
    logic              over;
    logic [NW-1:0]     clamp;
    logic [NW-1:0]     last;

    function automatic logic [AW-1:0] ring(input logic [AW-1:0] h, input logic [NW-1:0] k);
        logic [NW:0] s;
        s = (NW+1)'(h) + (NW+1)'(k);
        if (s >= (NW+1)'(DEPTH))
            s = s - (NW+1)'(DEPTH);
        return AW'(s);
    endfunction

    assign wslot = ring(head_reg, widx);
    assign rslot = ring(head_reg, ridx);
    assign over  = XW'(cmd_reg.count) > XW'(DEPTH);
    assign clamp = over ? DEPTH_N : NW'(cmd_reg.count);
    assign last  = cnt_reg - ONE_N;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wslot] <= wdata;
        rd_reg <= mem[rslot];
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.data  = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        lim_next   = lim_reg;
        a_next     = a_reg;
        key_next   = key_reg;
        rsp_next   = rsp_reg;
        st_next    = st_reg;
        we    = 1'b0;
        widx  = i_reg;
        wdata = a_reg;
        ridx  = i_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next   = cmd.data;
                    st_next    = ST_OK;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FRNT;
                i_next = '0;
                j_next = '0;
                a_next = cmd_reg.value;
                unique case (cmd_reg.mode)
                    MODE_PUSH_FRONT:
                        if (cnt_reg >= DEPTH_N)
                            st_next = ST_OVER;
                        else
                        begin
                            we        = 1'b1;
                            widx      = DEPTH_N - ONE_N;
                            wdata     = cmd_reg.value;
                            head_next = ring(head_reg, DEPTH_N - ONE_N);
                            cnt_next  = cnt_reg + ONE_N;
                        end
                    MODE_PUSH_BACK:
                        if (cnt_reg >= DEPTH_N)
                            st_next = ST_OVER;
                        else
                        begin
                            we       = 1'b1;
                            widx     = cnt_reg;
                            wdata    = cmd_reg.value;
                            cnt_next = cnt_reg + ONE_N;
                        end
                    MODE_POP_FRONT:
                        if (cnt_reg == '0)
                            st_next = ST_UNDER;
                        else
                        begin
                            head_next = ring(head_reg, ONE_N);
                            cnt_next  = cnt_reg - ONE_N;
                        end
                    MODE_POP_BACK:
                        if (cnt_reg == '0)
                            st_next = ST_UNDER;
                        else
                            cnt_next = cnt_reg - ONE_N;
                    MODE_ERASE:
                        if (XW'(cmd_reg.position) >= XW'(cnt_reg))
                            st_next = ST_BADPOS;
                        else
                        begin
                            i_next     = NW'(cmd_reg.position);
                            state_next = S_ER_RD;
                        end
                    MODE_CLEAR:
                        cnt_next = '0;
                    MODE_REVERSE:
                    begin
                        lim_next   = cnt_reg >> 1;
                        state_next = S_RV_RD;
                    end
                    MODE_SORT:
                    begin
                        i_next     = ONE_N;
                        state_next = S_SKEY;
                    end
                    MODE_RESIZE:
                    begin
                        if (over)
                            st_next = ST_OVER;
                        i_next     = cnt_reg;
                        a_next     = '0;
                        state_next = S_WR;
                    end
                    MODE_ASSIGN:
                    begin
                        if (over)
                            st_next = ST_OVER;
                        state_next = S_WR;
                    end
                    default: ;
                endcase
            end
            S_WR:
            begin
                if (i_reg < clamp)
                begin
                    we     = 1'b1;
                    i_next = i_reg + ONE_N;
                end
                else
                begin
                    cnt_next   = clamp;
                    state_next = S_FRNT;
                end
            end
            S_ER_RD:
            begin
                if (i_reg + ONE_N < cnt_reg)
                begin
                    ridx       = i_reg + ONE_N;
                    state_next = S_ER_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - ONE_N;
                    state_next = S_FRNT;
                end
            end
            S_ER_WR:
            begin
                we         = 1'b1;
                wdata      = rd_reg;
                i_next     = i_reg + ONE_N;
                state_next = S_ER_RD;
            end
            S_RV_RD:
            begin
                if (i_reg < lim_reg)
                    state_next = S_RV_FAR;
                else
                    state_next = S_FRNT;
            end
            S_RV_FAR:
            begin
                a_next     = rd_reg;
                ridx       = last - i_reg;
                state_next = S_RV_WN;
            end
            S_RV_WN:
            begin
                we         = 1'b1;
                wdata      = rd_reg;
                state_next = S_RV_WF;
            end
            S_RV_WF:
            begin
                we         = 1'b1;
                widx       = last - i_reg;
                wdata      = a_reg;
                i_next     = i_reg + ONE_N;
                state_next = S_RV_RD;
            end
            S_SKEY:
            begin
                if (i_reg < cnt_reg)
                begin
                    j_next     = i_reg;
                    state_next = S_SLOAD;
                end
                else
                    state_next = S_FRNT;
            end
            S_SLOAD:
            begin
                key_next   = rd_reg;
                ridx       = j_reg - ONE_N;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                we   = 1'b1;
                widx = j_reg;
                if (j_reg != '0 && $signed(rd_reg) > $signed(key_reg))
                begin
                    wdata  = rd_reg;
                    j_next = j_reg - ONE_N;
                    ridx   = (j_reg > ONE_N) ? j_reg - NW'(2) : '0;
                end
                else
                begin
                    wdata      = key_reg;
                    i_next     = i_reg + ONE_N;
                    state_next = S_SKEY;
                end
            end
            S_FRNT:
            begin
                ridx       = '0;
                state_next = S_BACK;
            end
            S_BACK:
            begin
                rsp_next.front_value = (cnt_reg == '0) ? '0 : rd_reg;
                ridx       = (cnt_reg == '0) ? '0 : last;
                state_next = S_BCAP;
            end
            S_BCAP:
            begin
                rsp_next.back_value = (cnt_reg == '0) ? '0 : rd_reg;
                rsp_next.occupancy  = CNT_W'(cnt_reg);
                rsp_next.is_empty   = (cnt_reg == '0);
                rsp_next.status     = st_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
            cmd_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            lim_reg   <= '0;
            a_reg     <= '0;
            key_reg   <= '0;
            rsp_reg   <= '0;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            cmd_reg   <= cmd_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            lim_reg   <= lim_next;
            a_reg     <= a_next;
            key_reg   <= key_next;
            rsp_reg   <= rsp_next;
            st_reg    <= st_next;
        end
    end

endmodule
